/* rtl/ffha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and types for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;
  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam int HDR = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  typedef struct packed {
    logic [15:0] off;
    logic [16:0] size;
    logic        free;
  } seg_t;

  // controller to datapath commands
  typedef struct packed {
    logic             init;     // reload single segment
    logic             load_req; // capture request
    logic             rd;       // read entry rd_idx
    logic [IDX_W-1:0] rd_idx;
    logic             wr;       // write wr_data to wr_idx
    logic [IDX_W-1:0] wr_idx;
    logic [2:0]       wr_sel;   // what to write
    logic             hold;     // latch read data into hold register
    logic             cnt_inc;
    logic             cnt_dec;
    logic             acc_clr;
    logic             acc_add;  // add read entry to free sum if free
    logic             set_res;  // capture result
    logic [1:0]       res_st;
    logic             res_grant;
  } ffha_cmd_t;

  typedef struct packed {
    seg_t             rd_data;
    seg_t             hold;
    logic [CNT_W-1:0] count;
    logic             fit;       // rd_data free and large enough
    logic             big;       // rd_data splittable
    logic             addr_hit;  // rd_data payload matches release address
    logic             zero_req;
    logic             null_rel;
    logic             kind;
  } ffha_sts_t;

  localparam logic [2:0] WR_COPY   = 3'd0; // hold register as is
  localparam logic [2:0] WR_ALLOC  = 3'd1; // hold, size need, busy
  localparam logic [2:0] WR_SPLIT  = 3'd2; // remainder segment
  localparam logic [2:0] WR_FREE   = 3'd3; // hold marked free
  localparam logic [2:0] WR_MERGE  = 3'd4; // hold grown by rd_data
  localparam logic [2:0] WR_BUSY   = 3'd5; // hold marked busy
endpackage

/* rtl/ffha_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] request_bytes;
  logic [31:0] release_address;
  modport source (output valid, kind, request_bytes, release_address, input ready);
  modport sink   (input valid, kind, request_bytes, release_address, output ready);
endinterface

interface ffha_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;
  logic [16:0] free_bytes;
  modport source (output valid, granted_address, status, free_bytes, input ready);
  modport sink   (input valid, granted_address, status, free_bytes, output ready);
endinterface

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ffha_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_datapath
// Segment table memory, request registers, free-byte sum and result register.
// ----------------------------------------------------------------------------
module ffha_datapath import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ffha_cmd_t   cmd,
  output ffha_sts_t   sts,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic        in_kind,
  input  logic [15:0] in_request_bytes,
  input  logic [31:0] in_release_address,
  output logic [31:0] res_granted,
  output logic [1:0]  res_status,
  output logic [16:0] res_free
);
  seg_t mem [MAX_SEGMENTS];
  seg_t rd_r, hold_r, wdat;
  logic [31:0] base_r;
  logic [16:0] clamp, init_bytes, sum_r, need_r;
  logic [15:0] rel_r;
  logic        relbig_r, kind_r, zero_r, null_r;
  logic [CNT_W-1:0] cnt_r;

  // heap size for the single-segment reload: full heap at reset, else the write
  always_comb begin
    clamp = cfg_data[16:0];
    if (clamp < 17'd64) clamp = 17'd64;
    if (clamp > 17'd65536) clamp = 17'd65536;
    init_bytes = rst_n ? clamp : 17'd65536;
  end

  always_comb begin
    wdat = hold_r;
    case (cmd.wr_sel)
      WR_COPY:  wdat = hold_r;
      WR_ALLOC: begin wdat.size = need_r; wdat.free = 1'b0; end
      WR_SPLIT: begin
        wdat.off  = 16'(hold_r.off + HDR + need_r);
        wdat.size = 17'(hold_r.size - need_r - HDR);
        wdat.free = 1'b1;
      end
      WR_FREE:  wdat.free = 1'b1;
      WR_MERGE: wdat.size = 17'(hold_r.size + HDR + rd_r.size);
      WR_BUSY:  wdat.free = 1'b0;
      default:  wdat = hold_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_r <= mem[cmd.rd_idx];
    if (!rst_n || cmd.init) mem[0] <= '{off: 16'd0,
                                        size: (init_bytes > 17'(HDR)) ?
                                              17'(init_bytes - HDR) : 17'd0,
                                        free: 1'b1};
    else if (cmd.wr) mem[cmd.wr_idx] <= wdat;
    if (cmd.hold) hold_r <= rd_r;
    if (cmd.load_req) begin
      kind_r <= in_kind;
      zero_r <= (in_request_bytes == 16'd0);
      null_r <= (in_release_address == 32'd0);
      need_r <= 17'((({1'b0, in_request_bytes} + 17'(ALIGN_BYTES - 1)) / ALIGN_BYTES)
                * ALIGN_BYTES);
      {relbig_r, rel_r} <= 17'((in_release_address - base_r - HDR) >> 0)
                           | {|(32'(in_release_address - base_r - HDR) >> 16), 16'd0};
    end
    if (cmd.acc_clr) sum_r <= '0;
    else if (cmd.acc_add && rd_r.free) sum_r <= 17'(sum_r + rd_r.size);
    if (cmd.set_res) begin
      res_status  <= cmd.res_st;
      res_granted <= cmd.res_grant ? 32'(base_r + hold_r.off + HDR) : 32'd0;
      res_free    <= sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      cnt_r  <= CNT_W'(1);
    end else begin
      if (cfg_we && cfg_idx == CFG_HEAP_BASE) base_r <= cfg_data;
      if (cmd.init) cnt_r <= CNT_W'(1);
      else if (cmd.cnt_inc) cnt_r <= CNT_W'(cnt_r + 1'b1);
      else if (cmd.cnt_dec) cnt_r <= CNT_W'(cnt_r - 1'b1);
    end
  end

  always_comb begin
    sts.rd_data  = rd_r;
    sts.hold     = hold_r;
    sts.count    = cnt_r;
    sts.fit      = rd_r.free && rd_r.size >= need_r;
    sts.big      = {1'b0, rd_r.size} >= 18'(need_r + HDR + ALIGN_BYTES);
    sts.addr_hit = !relbig_r && rd_r.off == rel_r;
    sts.zero_req = zero_r;
    sts.null_rel = null_r;
    sts.kind     = kind_r;
  end
endmodule

/* rtl/ffha_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: search, split insert, merge compaction and free-byte sum.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ffha_sts_t sts,
  output ffha_cmd_t cmd,
  input  logic      cfg_we,
  input  logic      cfg_heap,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_SRD = 4'd2, S_SCHK = 4'd3,
                         S_SHRD = 4'd4, S_SHWR = 4'd5, S_SPLIT = 4'd6, S_ALLOC = 4'd7,
                         S_MRD = 4'd8, S_MCHK = 4'd9, S_CRD = 4'd10, S_CWR = 4'd11,
                         S_ARD = 4'd12, S_AACC = 4'd13, S_RES = 4'd14, S_OUT = 4'd15;
  logic [3:0] st_r, st_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, hit_r, hit_nxt;
  logic [1:0] rs_r, rs_nxt;
  logic g_r, g_nxt, rdup_r, rdup_nxt;

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; hit_nxt = hit_r;
    rs_nxt = rs_r; g_nxt = g_r; rdup_nxt = rdup_r;
    cmd = '0;
    cmd.init = cfg_we && cfg_heap;
    in_ready = (st_r == S_IDLE);
    out_valid = (st_r == S_OUT);
    case (st_r)
      S_IDLE: if (in_valid) begin cmd.load_req = 1'b1; st_nxt = S_DEC; end
      S_DEC: begin
        rs_nxt = ST_OK; g_nxt = 1'b0; i_nxt = '0;
        if (!sts.kind && sts.zero_req) begin rs_nxt = ST_ZERO; st_nxt = S_ARD; end
        else if (sts.kind && sts.null_rel) st_nxt = S_ARD;
        else st_nxt = S_SRD;
      end
      S_SRD: begin
        if (i_r == sts.count) begin
          rs_nxt = sts.kind ? ST_UNKNOWN : ST_NOFIT; i_nxt = '0; st_nxt = S_ARD;
        end else begin
          cmd.rd = 1'b1; cmd.rd_idx = IDX_W'(i_r); st_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        cmd.hold = 1'b1;
        if (!sts.kind ? sts.fit : sts.addr_hit) begin
          hit_nxt = i_r;
          if (sts.kind) st_nxt = S_ALLOC;
          else if (sts.big && sts.count < CNT_W'(MAX_SEGMENTS)) begin
            j_nxt = sts.count; st_nxt = S_SHRD;
          end else begin
            // whole segment granted; j cleared so the grant keeps its size
            j_nxt = '0; st_nxt = S_ALLOC;
          end
        end else begin
          i_nxt = CNT_W'(i_r + 1'b1); st_nxt = S_SRD;
        end
      end
      // shift entries hit+1..count-1 up by one, from the top
      S_SHRD: begin
        if (j_r == CNT_W'(hit_r + 1'b1)) begin
          cmd.rd = 1'b1; cmd.rd_idx = IDX_W'(hit_r); st_nxt = S_SPLIT;
        end else begin
          cmd.rd = 1'b1; cmd.rd_idx = IDX_W'(j_r - 1'b1); st_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.hold = 1'b1; st_nxt = S_SPLIT;
        rdup_nxt = 1'b1;
      end
      S_SPLIT: begin
        if (rdup_r) begin
          cmd.wr = 1'b1; cmd.wr_idx = IDX_W'(j_r); cmd.wr_sel = WR_COPY;
          j_nxt = CNT_W'(j_r - 1'b1); rdup_nxt = 1'b0; st_nxt = S_SHRD;
        end else begin
          cmd.hold = 1'b1; st_nxt = S_ALLOC; rdup_nxt = 1'b1;
        end
      end
      S_ALLOC: begin
        if (sts.kind) begin
          cmd.wr = 1'b1; cmd.wr_idx = IDX_W'(hit_r); cmd.wr_sel = WR_FREE;
          i_nxt = '0; st_nxt = S_MRD;
        end else if (rdup_r) begin
          // hold = entry at hit; write remainder then shrink
          cmd.wr = 1'b1; cmd.wr_idx = IDX_W'(hit_r + 1'b1); cmd.wr_sel = WR_SPLIT;
          cmd.cnt_inc = 1'b1; rdup_nxt = 1'b0;
        end else begin
          cmd.wr = 1'b1; cmd.wr_idx = IDX_W'(hit_r);
          cmd.wr_sel = (j_r == CNT_W'(hit_r + 1'b1)) ? WR_ALLOC : WR_BUSY;
          g_nxt = 1'b1; cmd.res_grant = 1'b0; st_nxt = S_ARD; i_nxt = '0;
        end
      end
      // merge walk: hold = entry i, read i+1
      S_MRD: begin
        if (CNT_W'(i_r + 1'b1) >= sts.count) begin i_nxt = '0; st_nxt = S_ARD; end
        else begin
          cmd.rd = 1'b1; cmd.rd_idx = IDX_W'(i_r);
          st_nxt = S_MCHK; rdup_nxt = 1'b0;
        end
      end
      S_MCHK: begin
        if (!rdup_r) begin
          cmd.hold = 1'b1; cmd.rd = 1'b1; cmd.rd_idx = IDX_W'(i_r + 1'b1);
          rdup_nxt = 1'b1;
        end else begin
          rdup_nxt = 1'b0;
          if (sts.hold.free && sts.rd_data.free) begin
            cmd.wr = 1'b1; cmd.wr_idx = IDX_W'(i_r); cmd.wr_sel = WR_MERGE;
            cmd.cnt_dec = 1'b1; j_nxt = CNT_W'(i_r + 1'b1); st_nxt = S_CRD;
          end else begin
            i_nxt = CNT_W'(i_r + 1'b1); st_nxt = S_MRD;
          end
        end
      end
      // compaction: move j+1 down to j for j < count (count already decremented)
      S_CRD: begin
        if (j_r >= sts.count) st_nxt = S_MRD;
        else begin
          cmd.rd = 1'b1; cmd.rd_idx = IDX_W'(j_r + 1'b1); st_nxt = S_CWR; rdup_nxt = 1'b0;
        end
      end
      S_CWR: begin
        if (!rdup_r) begin cmd.hold = 1'b1; rdup_nxt = 1'b1; end
        else begin
          cmd.wr = 1'b1; cmd.wr_idx = IDX_W'(j_r); cmd.wr_sel = WR_COPY;
          j_nxt = CNT_W'(j_r + 1'b1); rdup_nxt = 1'b0; st_nxt = S_CRD;
        end
      end
      S_ARD: begin
        if (i_r == '0) cmd.acc_clr = 1'b1;
        if (i_r == sts.count) begin st_nxt = S_RES; end
        else begin cmd.rd = 1'b1; cmd.rd_idx = IDX_W'(i_r); st_nxt = S_AACC; end
      end
      S_AACC: begin
        cmd.acc_add = 1'b1; i_nxt = CNT_W'(i_r + 1'b1); st_nxt = S_ARD;
      end
      S_RES: begin
        cmd.set_res = 1'b1; cmd.res_st = rs_r; cmd.res_grant = g_r; st_nxt = S_OUT;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; i_r <= '0; j_r <= '0; hit_r <= '0;
      rs_r <= ST_OK; g_r <= 1'b0; rdup_r <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; j_r <= j_nxt; hit_r <= hit_nxt;
      rs_r <= rs_nxt; g_r <= g_nxt; rdup_r <= rdup_nxt;
    end
  end

  a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.cnt_inc && cmd.cnt_dec)) else $error("count conflict");
endmodule

/* rtl/first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit segment allocator with split on allocate and merge on release.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; the next transfer is taken the cycle after
//   the result transfer. The single segment table RAM port sets the pace.
// Reset: rst_n synchronous; table holds one free segment of 65536-HDR bytes,
//   base 0. Writing heap_bytes reloads the single segment.
module first_fit_heap_allocator import ffha_pkg::*; (
  input logic clk,
  input logic rst_n,
  ffha_req_if.sink   in_ch,
  ffha_res_if.source out_ch,
  ffha_cfg_if.sink   cfg_ch
);
  ffha_cmd_t cmd;
  ffha_sts_t sts;
  logic cfg_we;

  // config always taken; block is idle by contract
  assign cfg_ch.ready = 1'b1;
  assign cfg_we = cfg_ch.valid;

  ffha_ctrl u_ctrl (
    .clk, .rst_n, .sts, .cmd,
    .cfg_we, .cfg_heap(cfg_ch.index == CFG_HEAP_BYTES),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );

  ffha_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_we, .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data),
    .in_kind(in_ch.kind), .in_request_bytes(in_ch.request_bytes),
    .in_release_address(in_ch.release_address),
    .res_granted(out_ch.granted_address), .res_status(out_ch.status),
    .res_free(out_ch.free_bytes)
  );
endmodule

/* tb/heap_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_table_checker
// Watches the request, result and register channels of the allocator. It
// keeps its own segment table, works out the reply to every request and
// compares each reply, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module heap_table_checker import ffha_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  ffha_req_if     in_ch,
  ffha_res_if     out_ch,
  ffha_cfg_if     cfg_ch,
  output int      fail_count,
  output int      replies_pending,
  output int      replies_checked
);

  typedef struct {
    logic [31:0] granted_address;
    logic [1:0]  status;
    logic [16:0] free_bytes;
  } heap_reply_t;

  heap_reply_t awaited_replies[$];

  logic [31:0] base_addr;
  int unsigned heap_limit;
  int unsigned seg_off [MAX_SEGMENTS];
  int unsigned seg_len [MAX_SEGMENTS];
  bit          seg_idle[MAX_SEGMENTS];
  int unsigned seg_total;

  function automatic void rebuild_table();
    seg_off[0]  = 0;
    seg_len[0]  = (heap_limit > HDR) ? heap_limit - HDR : 0;
    seg_idle[0] = 1'b1;
    seg_total   = 1;
  endfunction

  function automatic logic [16:0] sum_free_bytes();
    int unsigned acc;
    acc = 0;
    for (int i = 0; i < seg_total; i++)
      if (seg_idle[i]) acc += seg_len[i];
    return acc[16:0];
  endfunction

  // merge every run of adjacent free segments
  function automatic void merge_free_runs();
    int unsigned i;
    i = 0;
    while (i + 1 < seg_total) begin
      if (seg_idle[i] && seg_idle[i+1]) begin
        seg_len[i] += HDR + seg_len[i+1];
        for (int j = i + 1; j + 1 < seg_total; j++) begin
          seg_off[j]  = seg_off[j+1];
          seg_len[j]  = seg_len[j+1];
          seg_idle[j] = seg_idle[j+1];
        end
        seg_total--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic heap_reply_t predict_heap_request(logic is_release, logic [15:0] req,
                                                       logic [31:0] addr);
    heap_reply_t rep;
    int unsigned need, hit;
    logic [31:0] rel;
    rep.granted_address = '0;
    rep.status          = ST_OK;
    if (!is_release) begin
      if (req == 0) begin
        rep.status = ST_ZERO;
      end else begin
        need = ((int'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        hit  = seg_total;
        for (int i = 0; i < seg_total; i++)
          if (seg_idle[i] && seg_len[i] >= need) begin
            hit = i;
            break;
          end
        if (hit == seg_total) begin
          rep.status = ST_NOFIT;
        end else begin
          // split only when the rest holds a header and one aligned unit
          if (seg_len[hit] >= need + HDR + ALIGN_BYTES && seg_total < MAX_SEGMENTS) begin
            for (int j = seg_total; j > hit + 1; j--) begin
              seg_off[j]  = seg_off[j-1];
              seg_len[j]  = seg_len[j-1];
              seg_idle[j] = seg_idle[j-1];
            end
            seg_off[hit+1]  = seg_off[hit] + HDR + need;
            seg_len[hit+1]  = seg_len[hit] - need - HDR;
            seg_idle[hit+1] = 1'b1;
            seg_len[hit]    = need;
            seg_total++;
          end
          seg_idle[hit] = 1'b0;
          rep.granted_address = base_addr + seg_off[hit] + HDR;
        end
      end
    end else if (addr != 0) begin
      rel = addr - base_addr;
      hit = seg_total;
      for (int i = 0; i < seg_total; i++)
        if (seg_off[i] + HDR == rel) begin
          hit = i;
          break;
        end
      if (hit == seg_total) begin
        rep.status = ST_UNKNOWN;
      end else begin
        seg_idle[hit] = 1'b1;
        merge_free_runs();
      end
    end
    rep.free_bytes = sum_free_bytes();
    return rep;
  endfunction

  assign replies_pending = awaited_replies.size();

  always @(posedge clk) begin
    heap_reply_t want;
    int unsigned v;
    int errs;
    errs = 0;
    if (!rst_n) begin
      base_addr = '0;
      heap_limit = 65536;
      rebuild_table();
      awaited_replies.delete();
      fail_count      <= 0;
      replies_checked <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_HEAP_BASE) begin
          base_addr = cfg_ch.data;
        end else begin
          v = cfg_ch.data[16:0];
          if (v < 64) v = 64;
          if (v > 65536) v = 65536;
          heap_limit = v;
          rebuild_table();
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_replies.push_back(predict_heap_request(in_ch.kind, in_ch.request_bytes,
                                                       in_ch.release_address));
      if (out_ch.valid && out_ch.ready) begin
        replies_checked <= replies_checked + 1;
        if (awaited_replies.size() == 0) begin
          $error("result transfer with no request outstanding");
          errs++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_ch.granted_address !== want.granted_address) begin
            $error("granted_address: expected %h, got %h", want.granted_address,
                   out_ch.granted_address);
            errs++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errs++;
          end
          if (out_ch.free_bytes !== want.free_bytes) begin
            $error("free_bytes: expected %0d, got %0d", want.free_bytes, out_ch.free_bytes);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the first-fit heap allocator. A directed pass hits
// the size extremes, null, unknown and repeated releases and the register
// clamps; a fill phase takes the table to its segment limit; then random
// phases under several heap settings mix allocations with releases of live
// addresses and add noise. Checking lives in heap_table_checker.
// ----------------------------------------------------------------------------
module testbench import ffha_pkg::*;;

  localparam int CYCLE_LIMIT = 4_000_000;

  logic clk;
  logic rst_n;

  ffha_req_if req_ch();
  ffha_res_if res_ch();
  ffha_cfg_if reg_ch();

  int fail_count, replies_pending, replies_checked;
  int alloc_sent, release_sent, settings_used;
  int cycle_count = 0;
  bit no_gaps;                 // set for stretches with no idling on either side

  logic [31:0] live_addrs[$];  // granted and not yet released
  logic [31:0] freed_addrs[$]; // released once, kept for repeat releases

  first_fit_heap_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (reg_ch)
  );

  heap_table_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (req_ch),
    .out_ch          (res_ch),
    .cfg_ch          (reg_ch),
    .fail_count      (fail_count),
    .replies_pending (replies_pending),
    .replies_checked (replies_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall before taking each transfer, none when no_gaps is set
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      res_ch.ready = 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      // grab addresses handed out so that releases can name real segments
      if (res_ch.status == ST_OK && res_ch.granted_address != 0)
        live_addrs.push_back(res_ch.granted_address);
    end
  end

  // one request transfer; valid stays high into the next item when no gap
  task automatic send_request(logic is_release, logic [15:0] req, logic [31:0] addr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.kind            = is_release;
    req_ch.request_bytes   = req;
    req_ch.release_address = addr;
    req_ch.valid           = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (is_release) release_sent++;
    else alloc_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (replies_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    reg_ch.index = idx;
    reg_ch.data  = value;
    reg_ch.valid = 1'b1;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    @(negedge clk);
    reg_ch.valid = 1'b0;
  endtask

  // new heap setting; old addresses are stale after the table reloads
  task automatic set_heap(logic [31:0] base, logic [31:0] size_bytes);
    wait_quiet();
    write_reg(CFG_HEAP_BASE, base);
    write_reg(CFG_HEAP_BYTES, size_bytes);
    live_addrs.delete();
    freed_addrs.delete();
    settings_used++;
  endtask

  task automatic release_live();
    int k;
    logic [31:0] a;
    k = $urandom_range(0, live_addrs.size() - 1);
    a = live_addrs[k];
    live_addrs.delete(k);
    freed_addrs.push_back(a);
    send_request(1'b1, 16'($urandom), a);
  endtask

  // one random item: mostly well-formed allocate/release traffic, some noise
  task automatic random_request();
    int pick;
    logic [15:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 85 && live_addrs.size() == 0)) begin
      case ($urandom_range(0, 19))
        0:       req = 16'd0;
        1:       req = 16'($urandom);
        2, 3:    req = 16'($urandom_range(257, 4096));
        default: req = 16'($urandom_range(1, 256));
      endcase
      send_request(1'b0, req, $urandom);
    end else if (pick < 85) begin
      release_live();
    end else if (pick < 91) begin
      send_request(1'b1, 16'($urandom), $urandom);
    end else if (pick < 94) begin
      send_request(1'b1, 16'($urandom), 32'd0);
    end else if (pick < 97 && freed_addrs.size() != 0) begin
      // release again: free already, or reused by a later allocation
      send_request(1'b1, 16'($urandom),
                   freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
    end else if (live_addrs.size() != 0) begin
      // misaligned pointer into a live payload
      send_request(1'b1, 16'($urandom), live_addrs[0] + $urandom_range(1, 7));
    end else begin
      send_request(1'b1, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [31:0] base;
    req_ch.valid = 1'b0;
    req_ch.kind = 1'b0;
    req_ch.request_bytes = '0;
    req_ch.release_address = '0;
    reg_ch.valid = 1'b0;
    reg_ch.index = CFG_HEAP_BASE;
    reg_ch.data = '0;
    alloc_sent = 0;
    release_sent = 0;
    settings_used = 1;
    no_gaps = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset setting: base 0, whole 64 KiB heap
    send_request(1'b0, 16'd0, '0);            // zero size
    send_request(1'b0, 16'd1, '0);            // rounds to 8, at 16
    send_request(1'b0, 16'hFFFF, '0);         // no fit
    send_request(1'b0, 16'd8, '0);            // at 40
    send_request(1'b1, 16'd0, 32'd0);         // null release
    send_request(1'b1, 16'd0, 32'h1234_5678); // unknown
    send_request(1'b1, 16'd0, 32'd40);
    send_request(1'b1, 16'd0, 32'd16);        // merges back to one segment
    send_request(1'b1, 16'd0, 32'd16);        // already free
    send_request(1'b0, 16'd65520, '0);        // exact fit of the whole heap
    send_request(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(1'b1, 16'd0, 32'd16);
    // smallest heap, top base: grant wraps past 2^32
    set_heap(32'hFFFF_FFFF, 32'd0);           // clamps to 64
    send_request(1'b0, 16'd48, '0);
    send_request(1'b0, 16'd1, '0);
    send_request(1'b1, 16'd0, 32'd15);
    send_request(1'b0, 16'd41, '0);
    set_heap(32'hA5A5_5A5A, 32'h0001_FFFF);   // clamps to 65536
    send_request(1'b0, 16'h7FFF, '0);
    send_request(1'b0, 16'h8000, '0);
    send_request(1'b0, 16'h8001, '0);

    // table fill: 63 splits, the 64th grant takes the rest whole
    set_heap(32'h0000_1000, 32'd65536);
    for (int i = 0; i < 66; i++) send_request(1'b0, 16'($urandom_range(1, 64)), '0);
    wait_quiet();
    while (live_addrs.size() != 0) release_live();

    // random phases under varied settings
    for (int phase = 0; phase < 6; phase++) begin
      base = $urandom;
      case (phase)
        0: set_heap(32'd0, 32'd65536);
        1: set_heap(32'hFFFF_FFF0, $urandom_range(64, 600));
        2: set_heap(base, $urandom_range(64, 65536));
        3: set_heap(base, $urandom_range(0, 63));
        4: set_heap(base, $urandom_range(2000, 8000));
        default: set_heap(base, $urandom_range(65537, 131071));
      endcase
      no_gaps = (phase == 2);
      for (int n = 0; n < 55; n++) random_request();
    end
    no_gaps = 1'b0;

    wait_quiet();
    repeat (300) @(posedge clk);
    $display("Sent %0d allocates and %0d releases over %0d heap settings;",
             alloc_sent, release_sent, settings_used);
    $display("checked %0d results, table filled to its segment limit once.", replies_checked);
    if (fail_count == 0 && replies_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
